FILE: design/green_lagrange_strain_kernel_core_macros.svh
// Assertion macros for the Green-Lagrange strain kernel.
// Used by the top level only; needs nothing else.
`ifndef GREEN_LAGRANGE_STRAIN_KERNEL_CORE_MACROS_SVH
`define GREEN_LAGRANGE_STRAIN_KERNEL_CORE_MACROS_SVH

// Same-cycle implication, off during reset.
`define GLSK_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glsk: implication check failed");

// Next-cycle implication, off during reset.
`define GLSK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glsk: next-cycle check failed");

`endif

FILE: design/glsk_pkg.sv
// Shared types, widths and helpers for the Green-Lagrange strain kernel.
// No dependencies.
package glsk_pkg;

    localparam int IN_W  = 32;
    localparam int OUT_W = 48;
    localparam int FW    = 33;   // F entry: Q7.24 plus identity
    localparam int PW    = 66;   // product of two F entries
    localparam int CW    = 68;   // sum of three products
    localparam int HW    = 65;   // high partial of a det term
    localparam int DW    = 104;  // det accumulation width
    localparam int ADDR_W = 3;

    localparam logic DIM_MODE_RESET = 1'b1;

    localparam logic signed [FW-1:0] Q_ONE = FW'(34'sd16777216);

    localparam logic signed [DW-1:0] SAT_HI = {{(DW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [DW-1:0] SAT_LO = {{(DW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic signed [IN_W-1:0] du_dx;
        logic signed [IN_W-1:0] dv_dy;
        logic signed [IN_W-1:0] dw_dz;
        logic signed [IN_W-1:0] du_dy;
        logic signed [IN_W-1:0] dv_dx;
        logic signed [IN_W-1:0] dv_dz;
        logic signed [IN_W-1:0] dw_dy;
        logic signed [IN_W-1:0] dw_dx;
        logic signed [IN_W-1:0] du_dz;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] strain_xx;
        logic signed [OUT_W-1:0] strain_yy;
        logic signed [OUT_W-1:0] strain_zz;
        logic signed [OUT_W-1:0] shear_xy;
        logic signed [OUT_W-1:0] shear_yz;
        logic signed [OUT_W-1:0] shear_xz;
        logic signed [OUT_W-1:0] volume_ratio;
        logic                    inverted;
    } t_out;

    typedef logic signed [FW-1:0] t_fval;
    typedef t_fval [8:0] t_fmat;    // row-major F
    typedef logic signed [CW-1:0] t_cval;
    typedef t_cval [5:0] t_cvec;    // C00 C11 C22 C01 C12 C02
    typedef logic signed [HW-1:0] t_hval;
    typedef t_hval [5:0] t_hvec;
    typedef logic signed [PW-1:0] t_lval;
    typedef t_lval [5:0] t_lvec;

    // Clamp a shifted value to the signed 48-bit range.
    function automatic logic signed [OUT_W-1:0] sat48(input logic signed [DW-1:0] x);
        logic signed [OUT_W-1:0] r;
        if (x > SAT_HI) begin
            r = SAT_HI[OUT_W-1:0];
        end else if (x < SAT_LO) begin
            r = SAT_LO[OUT_W-1:0];
        end else begin
            r = x[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: design/green_lagrange_strain_kernel_core.sv
// Green-Lagrange strain kernel: one beat in per cycle.
// Throughput: one beat per cycle; busy stays low, five-stage multiply/add pipeline.
// Reset (synchronous, active low) clears all valid bits and sets dimension_mode to 3D.
// Results stream out on a one-cycle strobe; the receiver cannot stall.
`include "green_lagrange_strain_kernel_core_macros.svh"
module green_lagrange_strain_kernel_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  glsk_pkg::t_in                  i_item,
    output logic                           o_valid,
    output glsk_pkg::t_out                 o_result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [glsk_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic            r_dim_mode;
    logic            w_accept;
    logic            w_f_valid;
    glsk_pkg::t_fmat w_f;
    logic            w_p_valid;
    glsk_pkg::t_cvec w_c;
    glsk_pkg::t_hvec w_dh;
    glsk_pkg::t_lvec w_dl;

    assign busy     = 1'b0;
    assign pready   = 1'b1;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_mode <= glsk_pkg::DIM_MODE_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_dim_mode <= pwdata[0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {31'd0, r_dim_mode};

    glsk_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_accept),
        .i_dim_mode (r_dim_mode),
        .i_item     (i_item),
        .o_valid    (w_f_valid),
        .o_f        (w_f)
    );

    glsk_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .i_f     (w_f),
        .o_valid (w_p_valid),
        .o_c     (w_c),
        .o_dh    (w_dh),
        .o_dl    (w_dl)
    );

    glsk_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_p_valid),
        .i_c      (w_c),
        .i_dh     (w_dh),
        .i_dl     (w_dl),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    `GLSK_ASSERT_IMPL(a_latency, i_clk, i_rst_n, w_accept, ##5 o_valid)
    `GLSK_ASSERT_NEXT(a_mid_valid, i_clk, i_rst_n, w_f_valid, ##1 w_p_valid)
    `GLSK_ASSERT_IMPL(a_pos_det, i_clk, i_rst_n, o_valid && !o_result.volume_ratio[47] && (o_result.volume_ratio != '0), !o_result.inverted)

endmodule

FILE: design/glsk_front.sv
// Input stage: builds F = I + grad u from one beat; in 2D mode the z-gradient terms are zeroed.
// Depends on glsk_pkg.
module glsk_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_dim_mode,
    input  glsk_pkg::t_in   i_item,
    output logic            o_valid,
    output glsk_pkg::t_fmat o_f
);

    logic            r_valid;
    glsk_pkg::t_fmat r_f;
    glsk_pkg::t_fmat n_f;

    function automatic glsk_pkg::t_fval ext(input logic signed [glsk_pkg::IN_W-1:0] v,
                                            input logic use_it);
        glsk_pkg::t_fval r;
        r = use_it ? glsk_pkg::FW'(v) : '0;
        return r;
    endfunction

    always_comb begin
        n_f[0] = ext(i_item.du_dx, 1'b1) + glsk_pkg::Q_ONE;
        n_f[1] = ext(i_item.du_dy, 1'b1);
        n_f[2] = ext(i_item.du_dz, i_dim_mode);
        n_f[3] = ext(i_item.dv_dx, 1'b1);
        n_f[4] = ext(i_item.dv_dy, 1'b1) + glsk_pkg::Q_ONE;
        n_f[5] = ext(i_item.dv_dz, i_dim_mode);
        n_f[6] = ext(i_item.dw_dx, i_dim_mode);
        n_f[7] = ext(i_item.dw_dy, i_dim_mode);
        n_f[8] = ext(i_item.dw_dz, i_dim_mode) + glsk_pkg::Q_ONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f <= n_f;
    end

    assign o_valid = r_valid;
    assign o_f     = r_f;

endmodule

FILE: design/glsk_prod.sv
// Multiply stages: products for C = F^T F and partial products for det F.
// Depends on glsk_pkg.
module glsk_prod (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  glsk_pkg::t_fmat i_f,
    output logic            o_valid,
    output glsk_pkg::t_cvec o_c,
    output glsk_pkg::t_hvec o_dh,
    output glsk_pkg::t_lvec o_dl
);

    logic                                r_valid_a;
    logic                                r_valid_b;
    logic signed [glsk_pkg::PW-1:0]      r_cp [6][3];
    logic signed [glsk_pkg::PW-1:0]      r_dp [6];
    glsk_pkg::t_fval                     r_dc [6];
    glsk_pkg::t_cvec                     r_c;
    glsk_pkg::t_hvec                     r_dh;
    glsk_pkg::t_lvec                     r_dl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    // Stage A: column dot-product terms and det pair products.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_cp[0][k] <= i_f[k*3+0] * i_f[k*3+0];
            r_cp[1][k] <= i_f[k*3+1] * i_f[k*3+1];
            r_cp[2][k] <= i_f[k*3+2] * i_f[k*3+2];
            r_cp[3][k] <= i_f[k*3+0] * i_f[k*3+1];
            r_cp[4][k] <= i_f[k*3+1] * i_f[k*3+2];
            r_cp[5][k] <= i_f[k*3+0] * i_f[k*3+2];
        end
        r_dp[0] <= i_f[0] * i_f[4];
        r_dp[1] <= i_f[0] * i_f[5];
        r_dp[2] <= i_f[1] * i_f[3];
        r_dp[3] <= i_f[1] * i_f[5];
        r_dp[4] <= i_f[2] * i_f[3];
        r_dp[5] <= i_f[2] * i_f[4];
        r_dc[0] <= i_f[8];
        r_dc[1] <= i_f[7];
        r_dc[2] <= i_f[8];
        r_dc[3] <= i_f[6];
        r_dc[4] <= i_f[7];
        r_dc[5] <= i_f[6];
    end

    // Stage B: sum C terms; split the low 64 bits of each 66-bit pair product against the third factor.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 6; i++) begin
            r_c[i]  <= glsk_pkg::CW'(r_cp[i][0]) + glsk_pkg::CW'(r_cp[i][1])
                     + glsk_pkg::CW'(r_cp[i][2]);
            r_dh[i] <= $signed(r_dp[i][63:32]) * r_dc[i];
            r_dl[i] <= $signed({1'b0, r_dp[i][31:0]}) * r_dc[i];
        end
    end

    assign o_valid = r_valid_b;
    assign o_c     = r_c;
    assign o_dh    = r_dh;
    assign o_dl    = r_dl;

endmodule

FILE: design/glsk_back.sv
// Output stages: det accumulation, rounding to Q23.24 and saturation.
// Depends on glsk_pkg.
module glsk_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  glsk_pkg::t_cvec i_c,
    input  glsk_pkg::t_hvec i_dh,
    input  glsk_pkg::t_lvec i_dl,
    output logic            o_valid,
    output glsk_pkg::t_out  o_result
);

    localparam int DW = glsk_pkg::DW;
    localparam logic signed [DW-1:0] ONE48  = DW'(1) <<< 48;
    localparam logic signed [DW-1:0] HALF24 = DW'(1) <<< 24;
    localparam logic signed [DW-1:0] HALF23 = DW'(1) <<< 23;
    localparam logic signed [DW-1:0] HALF47 = DW'(1) <<< 47;

    logic                    r_valid_c;
    logic                    r_valid_d;
    logic signed [DW-1:0]    r_det;
    glsk_pkg::t_out          r_part;
    glsk_pkg::t_out          r_result;
    logic signed [DW-1:0]    n_det;
    logic signed [DW-1:0]    n_term [6];
    glsk_pkg::t_out          n_part;
    glsk_pkg::t_out          n_result;

    always_comb begin
        for (int t = 0; t < 6; t++) begin
            n_term[t] = (DW'(i_dh[t]) <<< 32) + DW'(i_dl[t]);
        end
        n_det = n_term[0] - n_term[1] - n_term[2] + n_term[3] + n_term[4] - n_term[5];
    end

    always_comb begin
        n_part = '0;
        n_part.strain_xx = glsk_pkg::sat48((DW'(i_c[0]) - ONE48 + HALF24) >>> 25);
        n_part.strain_yy = glsk_pkg::sat48((DW'(i_c[1]) - ONE48 + HALF24) >>> 25);
        n_part.strain_zz = glsk_pkg::sat48((DW'(i_c[2]) - ONE48 + HALF24) >>> 25);
        n_part.shear_xy  = glsk_pkg::sat48((DW'(i_c[3]) + HALF23) >>> 24);
        n_part.shear_yz  = glsk_pkg::sat48((DW'(i_c[4]) + HALF23) >>> 24);
        n_part.shear_xz  = glsk_pkg::sat48((DW'(i_c[5]) + HALF23) >>> 24);
    end

    always_comb begin
        n_result              = r_part;
        n_result.volume_ratio = glsk_pkg::sat48((r_det + HALF47) >>> 48);
        n_result.inverted     = r_det[DW-1] || (r_det == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_c <= 1'b0;
            r_valid_d <= 1'b0;
        end else begin
            r_valid_c <= i_valid;
            r_valid_d <= r_valid_c;
        end
    end

    always_ff @(posedge i_clk) begin
        r_det    <= n_det;
        r_part   <= n_part;
        r_result <= n_result;
    end

    assign o_valid  = r_valid_d;
    assign o_result = r_result;

endmodule
